/* src/csc_pkg.sv */
package csc_pkg;

    // Longest query the cell row can hold; one cell per query byte.
    localparam int QUERY_MAX = 32;
    localparam int LEN_W     = $clog2(QUERY_MAX + 1);
    localparam int IDX_W     = 5;
    localparam int COUNT_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Item kinds carried in the low bits of the input tuser.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TEXT = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] byte_val;
    } cell_ctl_t;

    // Handed from the match stage to the count stage, one per accepted load, text or end beat.
    typedef struct packed {
        logic valid;
        logic match;
        logic finish;
        logic clear;
    } cnt_evt_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            c = b + 8'h20;
        end
        return c;
    endfunction

endpackage

/* src/csc_cell.sv */
module csc_cell import csc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl_i,
    input  logic      wr_en_i,
    input  logic      is_last_i,
    input  logic      prev_hit_i,
    output logic      hit_o,
    output logic      tail_o
);

    logic [7:0] q_reg;
    logic       hit_reg;
    logic       hit_next;

    // This cell's hit means the query prefix ending at this cell matched the
    // text ending at the newest byte.
    assign hit_next = prev_hit_i & (q_reg == ctl_i.byte_val);
    assign tail_o   = hit_next & is_last_i;
    assign hit_o    = hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            q_reg <= ctl_i.byte_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl_i.clear) begin
            hit_reg <= 1'b0;
        end else if (ctl_i.step) begin
            hit_reg <= hit_next;
        end
    end

endmodule

/* src/csc_counter.sv */
module csc_counter import csc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cnt_evt_t           evt_i,
    output logic               evt_ready_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COUNT_W-1:0] m_tdata,
    output logic [0:0]         m_tuser
);

    cnt_evt_t           evt_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_upd;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_valid_reg;
    logic               stall;

    // Only an end of text can be held up, and only by a result not yet taken.
    assign stall       = evt_reg.valid & evt_reg.finish & out_valid_reg & ~m_tready;
    assign evt_ready_o = ~stall;

    always_comb begin
        count_upd = count_reg;
        if (evt_reg.match && count_reg != COUNT_MAX) begin
            count_upd = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            evt_reg <= evt_i;
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (evt_reg.valid) begin
                if (evt_reg.finish) begin
                    out_valid_reg <= 1'b1;
                    count_reg     <= '0;
                end else if (evt_reg.clear) begin
                    count_reg <= '0;
                end else begin
                    count_reg <= count_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && evt_reg.valid && evt_reg.finish) begin
            out_count_reg <= count_upd;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_count_reg;
    assign m_tuser[0] = |out_count_reg;

endmodule

/* src/caseless_substring_counter.sv */
// Counts non-overlapping, case-insensitive occurrences of a query in a byte
// stream. Load the query first with load beats (one byte each, tlast on the
// last one); then stream the text one byte per beat and mark its last byte with
// tlast, or send an end beat for an empty text. Each end of text yields one
// result beat with the saturating count and a found flag; the closing beat is
// registered as an event, then as the result. One beat is taken every cycle
// while s_tready is high: every query byte sits in its own cell of a row, and
// all cells compare the new text byte in the same cycle, so the match for a
// byte is known before the next one arrives. s_tready falls only while a
// result waits on m_tready and a second end of text is already behind it.
module caseless_substring_counter import csc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // query_index[4:0], byte_value[12:5], zero[15:13]
    input  logic [15:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    // final_flag
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // match_count[31:0]
    output logic [31:0] m_tdata,
    // found[0]
    output logic [0:0]  m_tuser
);

    logic [1:0]           in_mode;
    logic [IDX_W-1:0]     in_idx;
    logic [7:0]           in_byte;
    logic                 accept;
    logic                 idx_ok;
    logic                 is_load;
    logic                 is_text;
    logic                 is_end;
    logic                 text_end;
    logic                 match;
    cell_ctl_t            ctl;
    cnt_evt_t             evt;
    logic [QUERY_MAX-1:0] wr_en;
    logic [QUERY_MAX-1:0] last_vec;
    logic [QUERY_MAX-1:0] prev_hit;
    logic [QUERY_MAX-1:0] hit;
    logic [QUERY_MAX-1:0] tail;
    logic [LEN_W-1:0]     query_len_reg;
    logic [LEN_W-1:0]     since_reg;
    logic [LEN_W-1:0]     since_inc;

    assign in_mode = s_tuser;
    assign in_idx  = s_tdata[4:0];
    assign in_byte = fold_byte(s_tdata[12:5]);
    assign accept  = s_tvalid & s_tready;
    assign idx_ok  = int'(in_idx) < QUERY_MAX;

    always_comb begin
        is_load = 1'b0;
        is_text = 1'b0;
        is_end  = 1'b0;
        case (in_mode)
            MODE_LOAD: is_load = accept & idx_ok;
            MODE_TEXT: is_text = accept;
            MODE_END:  is_end  = accept;
            default:   ;
        endcase
    end

    assign text_end     = is_text & s_tlast;
    assign ctl.step     = is_text;
    assign ctl.clear    = is_load | is_end | text_end;
    assign ctl.byte_val = in_byte;

    for (genvar j = 0; j < QUERY_MAX; j++) begin : g_cell
        assign wr_en[j]    = is_load && (int'(in_idx) == j);
        assign last_vec[j] = (query_len_reg == LEN_W'(j + 1));
        if (j == 0) begin : g_head
            assign prev_hit[j] = 1'b1;
        end else begin : g_link
            assign prev_hit[j] = hit[j-1];
        end
        csc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl_i      (ctl),
            .wr_en_i    (wr_en[j]),
            .is_last_i  (last_vec[j]),
            .prev_hit_i (prev_hit[j]),
            .hit_o      (hit[j]),
            .tail_o     (tail[j])
        );
    end

    // A match counts only if it starts at or after the end of the previous one.
    assign since_inc = (since_reg < LEN_W'(QUERY_MAX)) ? since_reg + LEN_W'(1) : since_reg;
    assign match     = is_text & (|tail) & (since_inc >= query_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_len_reg <= '0;
            since_reg     <= '0;
        end else begin
            if (is_load) begin
                query_len_reg <= s_tlast ? LEN_W'(in_idx) + LEN_W'(1) : '0;
            end
            if (ctl.clear || match) begin
                since_reg <= '0;
            end else if (is_text) begin
                since_reg <= since_inc;
            end
        end
    end

    assign evt.valid  = is_load | is_text | is_end;
    assign evt.match  = match;
    assign evt.finish = is_end | text_end;
    assign evt.clear  = is_load;

    csc_counter u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .evt_i       (evt),
        .evt_ready_o (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* src/csc_checker.sv */
module csc_checker import csc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic end_beat;

    assign end_beat = s_tvalid && s_tready &&
                      (s_tuser == MODE_END ||
                       (s_tuser == MODE_TEXT && s_tlast));

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_found_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] == (m_tdata != 32'd0))
        else $error("found flag disagrees with count");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(end_beat, 2))
        else $error("result beat without an end of text two cycles before");

endmodule

bind caseless_substring_counter csc_checker u_chk (.*);

/* tb/sv/caseless_substring_counter_test.sv */
module caseless_substring_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int CALM_ITEMS     = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] qidx;
        logic [7:0]       bval;
        logic             fin;
    } text_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
    } tally_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    caseless_substring_counter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the block's state.
    logic [7:0]         pattern [QUERY_MAX];
    logic [LEN_W-1:0]   pattern_len = '0;
    logic [7:0]         tail_bytes [QUERY_MAX];
    logic [LEN_W-1:0]   bytes_since_hit = '0;
    logic [COUNT_W-1:0] hit_tally = '0;

    tally_t     due_counts [$];
    text_item_t pending [$];

    int n_accepted  = 0;
    int n_queued    = 0;
    int n_errors    = 0;
    int total_items = 0;
    int calm_from   = 0;
    int pressure_at = 0;

    // Stimulus bookkeeping: the current query and which store entries hold data.
    logic [7:0] gen_query [$];
    bit         pat_written [QUERY_MAX];

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
    endfunction

    function automatic bit window_hit();
        if (pattern_len == 0) return 1'b0;
        for (int i = 0; i < pattern_len; i++) begin
            if (pattern[i] != tail_bytes[pattern_len - 1 - i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic forget_text();
        foreach (tail_bytes[i]) tail_bytes[i] = 8'h00;
        bytes_since_hit = '0;
        hit_tally = '0;
    endtask

    task automatic close_text();
        tally_t res;
        res.count = hit_tally;
        res.found = (hit_tally != 0);
        due_counts = {due_counts, res};
        forget_text();
    endtask

    task automatic advance_counter(input text_item_t it);
        logic [7:0] c;
        c = to_lower(it.bval);
        case (it.mode)
            MODE_LOAD: begin
                pattern[it.qidx] = c;
                pattern_len = it.fin ? LEN_W'(it.qidx) + LEN_W'(1) : '0;
                forget_text();
            end
            MODE_TEXT: begin
                for (int i = QUERY_MAX - 1; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
                tail_bytes[0] = c;
                if (bytes_since_hit < QUERY_MAX) bytes_since_hit++;
                // A match only counts once the previous one has been left behind.
                if (pattern_len != 0 && bytes_since_hit >= pattern_len && window_hit()) begin
                    if (hit_tally != COUNT_MAX) hit_tally++;
                    bytes_since_hit = '0;
                end
                if (it.fin) close_text();
            end
            MODE_END: begin
                close_text();
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // ---------------- stimulus generation ----------------

    task automatic queue_item(input logic [1:0] mode, input logic [IDX_W-1:0] qidx,
                              input logic [7:0] bval, input logic fin);
        text_item_t it;
        it.mode = mode;
        it.qidx = qidx;
        it.bval = bval;
        it.fin  = fin;
        pending = {pending, it};
        if (mode == MODE_LOAD) pat_written[qidx] = 1'b1;
        if (mode != MODE_UNUSED) n_queued++;
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        if (low >= 8'h61 && low <= 8'h7a && $urandom_range(0, 1) == 1) return b ^ 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] query_byte();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1, 2, 3: return mixed_case(8'h61 + 8'($urandom_range(0, 25)));
            default: return mixed_case(8'h61 + 8'($urandom_range(0, 1)));
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && gen_query.size() > 0)
            return mixed_case(gen_query[$urandom_range(0, gen_query.size() - 1)]);
        if (r < 9) return mixed_case(8'h61 + 8'($urandom_range(0, 1)));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic load_query(input int len);
        gen_query.delete();
        for (int i = 0; i < len; i++) gen_query = {gen_query, query_byte()};
        for (int i = 0; i < len; i++)
            queue_item(MODE_LOAD, IDX_W'(i), gen_query[i], i == len - 1);
    endtask

    task automatic add_text();
        logic [7:0] txt [$];
        int segs;
        int k;
        segs = $urandom_range(0, 6);
        for (int g = 0; g < segs; g++) begin
            k = $urandom_range(0, 5);
            if (gen_query.size() > 0 && k < 2) begin
                foreach (gen_query[j]) txt = {txt, mixed_case(gen_query[j])};
            end else if (gen_query.size() > 1 && k == 2) begin
                // A near miss: only a prefix of the query.
                k = $urandom_range(1, gen_query.size() - 1);
                for (int j = 0; j < k; j++) txt = {txt, mixed_case(gen_query[j])};
            end else begin
                repeat ($urandom_range(1, 6)) txt = {txt, filler_byte()};
            end
        end
        if (txt.size() == 0 || $urandom_range(0, 9) == 0) begin
            foreach (txt[j])
                queue_item(MODE_TEXT, IDX_W'($urandom_range(0, 31)), txt[j], 1'b0);
            queue_item(MODE_END, IDX_W'($urandom_range(0, 31)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            foreach (txt[j])
                queue_item(MODE_TEXT, IDX_W'($urandom_range(0, 31)), txt[j],
                           j == txt.size() - 1);
        end
    endtask

    task automatic add_noise();
        logic [1:0]       mode;
        logic [IDX_W-1:0] qidx;
        logic             fin;
        mode = 2'($urandom_range(0, 3));
        qidx = IDX_W'($urandom_range(0, 31));
        fin  = 1'($urandom_range(0, 1));
        // A final load must never expose a store entry that holds no data yet.
        if (mode == MODE_LOAD && fin) begin
            for (int i = 0; i < qidx; i++) if (!pat_written[i]) fin = 1'b0;
        end
        queue_item(mode, qidx, 8'($urandom_range(0, 255)), fin);
    endtask

    task automatic build_stimulus();
        int r;
        int len;
        // Empty query: nothing can ever match.
        queue_item(MODE_END,  5'd0, 8'h00, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h61, 1'b1);
        // Query "Ab" against mixed-case copies, three matches.
        queue_item(MODE_LOAD, 5'd0, 8'h41, 1'b0);
        queue_item(MODE_LOAD, 5'd1, 8'h62, 1'b1);
        queue_item(MODE_TEXT, 5'd0, 8'h61, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h42, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h41, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h62, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h61, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h62, 1'b1);
        // Query "aA" in "aaa": overlapping occurrences count once.
        queue_item(MODE_LOAD, 5'd0, 8'h61, 1'b0);
        queue_item(MODE_LOAD, 5'd1, 8'h41, 1'b1);
        queue_item(MODE_TEXT, 5'd0, 8'h61, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h41, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h61, 1'b1);
        // The unused mode is dropped; an end beat then closes a text early.
        queue_item(MODE_UNUSED, 5'd31, 8'hff, 1'b1);
        queue_item(MODE_TEXT, 5'd31, 8'h61, 1'b0);
        queue_item(MODE_TEXT, 5'd31, 8'h61, 1'b0);
        queue_item(MODE_END,  5'd31, 8'hff, 1'b1);
        // Folding edges: 'Z' folds, '@' and '`' do not.
        queue_item(MODE_LOAD, 5'd0, 8'h5a, 1'b0);
        queue_item(MODE_LOAD, 5'd1, 8'h40, 1'b1);
        queue_item(MODE_TEXT, 5'd0, 8'h7a, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h60, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h5a, 1'b0);
        queue_item(MODE_TEXT, 5'd0, 8'h40, 1'b1);
        pressure_at = pending.size();

        // Many ends of text in a row while the receiver is held off.
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0) queue_item(MODE_END, 5'd0, 8'h00, 1'b0);
            else queue_item(MODE_TEXT, 5'd3, 8'h5a, 1'b1);
        end

        n_queued = 0;
        while (n_queued < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                repeat ($urandom_range(1, 4)) add_noise();
            end else if (r < 12) begin
                // An unfinished load leaves the query empty.
                repeat ($urandom_range(1, 3))
                    queue_item(MODE_LOAD, IDX_W'($urandom_range(0, 31)), query_byte(), 1'b0);
                add_text();
                add_text();
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0) len = QUERY_MAX;
                else if (r < 3) len = $urandom_range(7, QUERY_MAX - 1);
                else len = $urandom_range(1, 6);
                load_query(len);
                repeat ($urandom_range(2, 5)) add_text();
            end
        end
    endtask

    // ---------------- sender ----------------

    text_item_t offered;
    logic       tx_next_valid;
    int         tx_gap   = 0;
    int         tx_rate  = 0;
    int         tx_phase = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            tx_next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                advance_counter(offered);
                n_accepted <= n_accepted + 1;
                tx_next_valid = 1'b0;
            end
            if (tx_phase == 0) begin
                tx_phase = 64;
                case ($urandom_range(0, 2))
                    0:       tx_rate = 0;
                    1:       tx_rate = 10;
                    default: tx_rate = 40;
                endcase
            end
            tx_phase--;
            if (!tx_next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending.size() > 0) begin
                    if (n_accepted < calm_from && $urandom_range(0, 99) < tx_rate) begin
                        tx_gap = $urandom_range(0, 9);
                    end else begin
                        offered = pending.pop_front();
                        tx_next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= tx_next_valid;
            s_tdata  <= {3'b000, offered.bval, offered.qidx};
            s_tuser  <= offered.mode;
            s_tlast  <= offered.fin;
        end
    end

    // ---------------- receiver ----------------

    int rx_hold      = 0;
    bit rx_held_once = 1'b0;
    int rx_stall     = 0;
    int rx_rate      = 0;
    int rx_phase     = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!rx_held_once && n_accepted >= pressure_at) begin
                rx_held_once = 1'b1;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_phase == 0) begin
                rx_phase = 50;
                case ($urandom_range(0, 2))
                    0:       rx_rate = 0;
                    1:       rx_rate = 15;
                    default: rx_rate = 50;
                endcase
            end
            rx_phase--;
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (n_accepted >= calm_from) begin
                m_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_rate) begin
                rx_stall = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- result check ----------------

    tally_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (due_counts.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata, 32'd0);
            end else begin
                want = due_counts.pop_front();
                if (m_tdata !== want.count) report_mismatch("match_count", m_tdata, want.count);
                if (m_tuser[0] !== want.found)
                    report_mismatch("found", 32'(m_tuser), 32'(want.found));
            end
        end
    end

    // ---------------- watchdog ----------------

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        forget_text();
        foreach (pattern[i]) pattern[i] = 8'h00;
        build_stimulus();
        total_items = pending.size();
        calm_from = total_items - CALM_ITEMS;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_accepted < total_items || due_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_counts.size() != 0)
            report_mismatch("results never delivered", 32'd0, 32'(due_counts.size()));
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
src/csc_pkg.sv
src/csc_cell.sv
src/csc_counter.sv
src/caseless_substring_counter.sv
src/csc_checker.sv
tb/sv/caseless_substring_counter_test.sv
